@@ sv/u8d_pkg.sv @@
package u8d_pkg;

	localparam int unsigned CP_W        = 21;
	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [CP_W-1:0] REPL_CP = 21'h00FFFD;

	// One request's worth of work for the back end: n_repl replacements,
	// then optionally one final result.
	typedef struct packed {
		logic [1:0]      n_repl;
		logic            has_fin;
		logic [CP_W-1:0] fin_cp;
		logic            fin_repl;
	} cmd_t;

endpackage

@@ sv/u8d_front.sv @@
module u8d_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      text_byte,
	input  logic            end_of_text,
	input  logic            q_full,
	output logic            q_push,
	output u8d_pkg::cmd_t   q_cmd
);

	logic [1:0]                  exp_q, exp_d;
	logic [1:0]                  rcv_q, rcv_d;
	logic [u8d_pkg::CP_W-1:0]    pv_q, pv_d;

	logic                        fr_has, fr_repl, fr_open;
	logic [u8d_pkg::CP_W-1:0]    fr_cp, fr_val;
	logic [1:0]                  fr_need;
	logic [u8d_pkg::CP_W-1:0]    nv;
	logic [1:0]                  nr;
	logic                        accept;
	u8d_pkg::cmd_t               cmd;

	// decode of the byte as if no sequence were open
	always_comb begin
		fr_has  = 1'b0;
		fr_repl = 1'b0;
		fr_open = 1'b0;
		fr_cp   = {{(u8d_pkg::CP_W-8){1'b0}}, text_byte};
		fr_val  = '0;
		fr_need = 2'd0;
		if (text_byte inside {[8'h00:8'h7F]}) begin
			fr_has = 1'b1;
		end else if (text_byte inside {[8'hC0:8'hF7]}) begin
			if (text_byte inside {[8'hC0:8'hDF]}) begin
				fr_need = 2'd1;
				fr_val  = {{(u8d_pkg::CP_W-5){1'b0}}, text_byte[4:0]};
			end else if (text_byte inside {[8'hE0:8'hEF]}) begin
				fr_need = 2'd2;
				fr_val  = {{(u8d_pkg::CP_W-4){1'b0}}, text_byte[3:0]};
			end else begin
				fr_need = 2'd3;
				fr_val  = {{(u8d_pkg::CP_W-3){1'b0}}, text_byte[2:0]};
			end
			if (end_of_text) begin
				fr_has  = 1'b1;
				fr_cp   = u8d_pkg::REPL_CP;
				fr_repl = 1'b1;
			end else begin
				fr_open = 1'b1;
			end
		end else begin
			fr_has  = 1'b1;
			fr_cp   = u8d_pkg::REPL_CP;
			fr_repl = 1'b1;
		end
	end

	assign nv = {pv_q[u8d_pkg::CP_W-7:0], text_byte[5:0]};
	assign nr = rcv_q + 2'd1;

	always_comb begin
		cmd   = '0;
		exp_d = exp_q;
		rcv_d = rcv_q;
		pv_d  = pv_q;
		if (exp_q == 2'd0) begin
			cmd.has_fin  = fr_has;
			cmd.fin_cp   = fr_cp;
			cmd.fin_repl = fr_repl;
			if (fr_open) begin
				exp_d = fr_need;
				rcv_d = 2'd0;
				pv_d  = fr_val;
			end
		end else if (text_byte[7:6] == 2'b10) begin
			if (nr >= exp_q) begin
				cmd.has_fin = 1'b1;
				cmd.fin_cp  = nv;
				exp_d = 2'd0;
				rcv_d = 2'd0;
				pv_d  = '0;
			end else if (end_of_text) begin
				cmd.has_fin  = 1'b1;
				cmd.fin_cp   = u8d_pkg::REPL_CP;
				cmd.fin_repl = 1'b1;
				exp_d = 2'd0;
				rcv_d = 2'd0;
				pv_d  = '0;
			end else begin
				rcv_d = nr;
				pv_d  = nv;
			end
		end else begin
			// bad continuation: lead plus buffered bytes, then decode afresh
			cmd.n_repl   = (rcv_q >= 2'd2) ? 2'd3 : nr;
			cmd.has_fin  = fr_has;
			cmd.fin_cp   = fr_cp;
			cmd.fin_repl = fr_repl;
			exp_d = 2'd0;
			rcv_d = 2'd0;
			pv_d  = '0;
			if (fr_open) begin
				exp_d = fr_need;
				pv_d  = fr_val;
			end
		end
		if (end_of_text) begin
			exp_d = 2'd0;
			rcv_d = 2'd0;
			pv_d  = '0;
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;
	assign q_push = accept && ((cmd.n_repl != 2'd0) || cmd.has_fin);
	assign q_cmd  = cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q <= 2'd0;
			rcv_q <= 2'd0;
			pv_q  <= '0;
		end else if (accept) begin
			exp_q <= exp_d;
			rcv_q <= rcv_d;
			pv_q  <= pv_d;
		end
	end

endmodule

@@ sv/u8d_fifo.sv @@
module u8d_fifo #(
	parameter int unsigned Depth = u8d_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  u8d_pkg::cmd_t   wr_cmd,
	output logic            q_full,
	input  logic            rd_en,
	output logic            q_valid,
	output u8d_pkg::cmd_t   rd_cmd
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	u8d_pkg::cmd_t    mem_q [Depth];
	logic [PtrW-1:0]  wp_q, rp_q;
	logic [CntW-1:0]  cnt_q;
	logic             do_wr, do_rd;

	assign q_full  = (cnt_q == FullCnt);
	assign q_valid = (cnt_q != '0);
	assign rd_cmd  = mem_q[rp_q];
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && q_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == LastIdx) ? '0 : wp_q + PtrW'(1);
			end
			if (do_rd) begin
				rp_q <= (rp_q == LastIdx) ? '0 : rp_q + PtrW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CntW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CntW'(1);
			end
		end
	end

endmodule

@@ sv/u8d_back.sv @@
module u8d_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  u8d_pkg::cmd_t              q_cmd,
	output logic                       q_pop,
	output logic                       empty,
	input  logic                       pop,
	output logic [u8d_pkg::CP_W-1:0]   code_point,
	output logic                       is_replacement,
	output logic                       last_of_run
);

	logic [1:0]                  done_q;
	logic                        ov_q;
	logic [u8d_pkg::CP_W-1:0]    cp_q;
	logic                        repl_q, last_q;
	logic                        load, emit_repl, last;

	assign load      = q_valid && (!ov_q || pop);
	assign emit_repl = (done_q < q_cmd.n_repl);
	assign last      = emit_repl ? ((done_q + 2'd1 == q_cmd.n_repl) && !q_cmd.has_fin) : 1'b1;
	assign q_pop     = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 2'd0;
			ov_q   <= 1'b0;
		end else begin
			if (q_pop) begin
				done_q <= 2'd0;
			end else if (load) begin
				done_q <= done_q + 2'd1;
			end
			if (load) begin
				ov_q <= 1'b1;
			end else if (pop) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q   <= emit_repl ? u8d_pkg::REPL_CP : q_cmd.fin_cp;
			repl_q <= emit_repl ? 1'b1 : q_cmd.fin_repl;
			last_q <= last;
		end
	end

	assign empty          = !ov_q;
	assign code_point     = cp_q;
	assign is_replacement = repl_q;
	assign last_of_run    = last_q;

endmodule

@@ sv/utf8_stream_decoder.sv @@
// channel   | dir | request moves on         | payload
// ----------+-----+--------------------------+------------------------------------------
// byte in   | in  | push & !full             | text_byte, end_of_text
// result    | out | pop & !empty             | code_point, is_replacement, last_of_run
//
// One byte per cycle is taken while the command queue has room; a result leaves the
// output register one per cycle while pop is held. A byte that causes n results holds
// the back end until all n are loaded, so error runs of up to four results fill the
// queue and push back on full. Results pass through the command queue, then the output
// register. Reset is asynchronous; afterwards no sequence is open and both are empty.
module utf8_stream_decoder #(
	parameter int unsigned QueueDepth = u8d_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 text_byte,
	input  logic                       end_of_text,
	output logic                       empty,
	input  logic                       pop,
	output logic [u8d_pkg::CP_W-1:0]   code_point,
	output logic                       is_replacement,
	output logic                       last_of_run
);

	logic            q_push, q_full, q_pop, q_valid;
	u8d_pkg::cmd_t   wr_cmd, rd_cmd;

	u8d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (wr_cmd)
	);

	u8d_fifo #(
		.Depth (QueueDepth)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_cmd  (wr_cmd),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.q_valid (q_valid),
		.rd_cmd  (rd_cmd)
	);

	u8d_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_cmd          (rd_cmd),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.code_point     (code_point),
		.is_replacement (is_replacement),
		.last_of_run    (last_of_run)
	);

endmodule

@@ sv/u8d_props.sv @@
module u8d_props (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       empty,
	input logic                       pop,
	input logic [u8d_pkg::CP_W-1:0]   code_point,
	input logic                       is_replacement,
	input logic                       last_of_run
);

	// a waiting result stays put until taken
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(code_point)
			&& $stable(is_replacement) && $stable(last_of_run))
		else $error("result changed while stalled");

	a_repl_cp: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && is_replacement |-> code_point == u8d_pkg::REPL_CP)
		else $error("replacement flag without U+FFFD");

	// only the closing result of a run can be a real code point
	a_real_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !is_replacement |-> last_of_run)
		else $error("decoded code point not last of run");

endmodule

bind utf8_stream_decoder u8d_props u_props (.*);

@@ sim/tb_utf8_stream_decoder.sv @@
module tb_utf8_stream_decoder;

	localparam int unsigned N_ITEMS     = 310;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned CpW         = u8d_pkg::CP_W;

	typedef struct packed {
		logic [CpW-1:0] cp;
		logic           repl;
		logic           last_flag;
	} cp_res_t;

	// decodes each accepted request and holds the code points still owed
	class code_point_ledger;
		cp_res_t         due[$];
		cp_res_t         run[$];
		bit [1:0]        need_cont;
		bit [1:0]        got_cont;
		bit [CpW-1:0]    acc;
		int unsigned     errors;

		function new();
			need_cont = 0;
			got_cont  = 0;
			acc       = 0;
			errors    = 0;
		endfunction

		function void emit(bit [CpW-1:0] cp, bit repl);
			cp_res_t r;
			r.cp        = cp;
			r.repl      = repl;
			r.last_flag = 1'b0;
			if (run.size() < 4) run.insert(run.size(), r);
		endfunction

		function void close_seq();
			need_cont = 0;
			got_cont  = 0;
			acc       = 0;
		endfunction

		function void decode_fresh(bit [7:0] b, bit eot);
			bit [1:0]     n;
			bit [CpW-1:0] v;
			n = 0;
			v = 0;
			casez (b)
				8'b0???????: begin
					emit(CpW'(b), 1'b0);
					return;
				end
				8'b110?????: begin
					n = 1;
					v = CpW'(b[4:0]);
				end
				8'b1110????: begin
					n = 2;
					v = CpW'(b[3:0]);
				end
				8'b11110???: begin
					n = 3;
					v = CpW'(b[2:0]);
				end
				default: begin
					emit(u8d_pkg::REPL_CP, 1'b1);
					return;
				end
			endcase
			if (eot) begin
				emit(u8d_pkg::REPL_CP, 1'b1);
				close_seq();
				return;
			end
			need_cont = n;
			got_cont  = 0;
			acc       = v;
		endfunction

		function void note_byte(bit [7:0] b, bit eot);
			int k;
			run.delete();
			if (need_cont == 0) begin
				decode_fresh(b, eot);
			end else if (b[7:6] == 2'b10) begin
				acc      = {acc[CpW-7:0], b[5:0]};
				got_cont = got_cont + 2'd1;
				if (got_cont >= need_cont) begin
					emit(acc, 1'b0);
					close_seq();
				end else if (eot) begin
					emit(u8d_pkg::REPL_CP, 1'b1);
					close_seq();
				end
			end else begin
				k = (got_cont > 2) ? 2 : int'(got_cont);
				emit(u8d_pkg::REPL_CP, 1'b1);
				repeat (k) emit(u8d_pkg::REPL_CP, 1'b1);
				close_seq();
				decode_fresh(b, eot);
			end
			if (eot) close_seq();
			if (run.size() > 0) run[run.size()-1].last_flag = 1'b1;
			foreach (run[i]) due.insert(due.size(), run[i]);
		endfunction

		function void check_result(bit [CpW-1:0] cp, bit repl, bit last_flag);
			cp_res_t w;
			if (due.size() == 0) begin
				errors++;
				$display("%0t: unexpected result cp=%h repl=%b last=%b",
					$time, cp, repl, last_flag);
				return;
			end
			w = due.pop_front();
			if (w.cp !== cp) begin
				errors++;
				$display("%0t: code_point expected %h actual %h", $time, w.cp, cp);
			end
			if (w.repl !== repl) begin
				errors++;
				$display("%0t: is_replacement expected %b actual %b", $time, w.repl, repl);
			end
			if (w.last_flag !== last_flag) begin
				errors++;
				$display("%0t: last_of_run expected %b actual %b",
					$time, w.last_flag, last_flag);
			end
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            push;
	logic            full;
	logic [7:0]      text_byte;
	logic            end_of_text;
	logic            empty;
	logic            pop;
	logic [CpW-1:0]  code_point;
	logic            is_replacement;
	logic            last_of_run;

	code_point_ledger ledger;
	int unsigned      n_sent;
	int unsigned      n_cycles;
	bit               tx_calm;
	bit               rx_calm;

	utf8_stream_decoder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.text_byte      (text_byte),
		.end_of_text    (end_of_text),
		.empty          (empty),
		.pop            (pop),
		.code_point     (code_point),
		.is_replacement (is_replacement),
		.last_of_run    (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function int unsigned tx_gap();
		int unsigned r;
		if ($urandom_range(0, 99) < 3) tx_calm = ~tx_calm;
		if (tx_calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	task automatic send_byte(input bit [7:0] b, input bit eot);
		int unsigned g;
		g = tx_gap();
		if (g > 0) begin
			push <= 1'b0;
			repeat (g) @(posedge clk);
		end
		push        <= 1'b1;
		text_byte   <= b;
		end_of_text <= eot;
		do @(posedge clk); while (full);
		ledger.note_byte(b, eot);
		n_sent++;
	endtask

	function bit [7:0] rand_cont();
		return 8'h80 | 8'($urandom_range(0, 63));
	endfunction

	function bit [7:0] rand_lead(int unsigned len);
		case (len)
			1: return 8'($urandom_range(0, 127));
			2: return 8'hC0 | 8'($urandom_range(0, 31));
			3: return 8'hE0 | 8'($urandom_range(0, 15));
			default: return 8'hF0 | 8'($urandom_range(0, 7));
		endcase
	endfunction

	task automatic send_random_text();
		bit [7:0]    seq[$];
		bit          eots[$];
		int unsigned kind;
		int unsigned len;
		int unsigned cut;
		bit [7:0]    b;
		while (n_sent < N_ITEMS) begin
			seq.delete();
			eots.delete();
			kind = $urandom_range(0, 99);
			len  = $urandom_range(1, 4);
			if (kind < 70) begin
				seq.insert(seq.size(), rand_lead(len));
				for (int i = 1; i < len; i++) seq.insert(seq.size(), rand_cont());
				foreach (seq[i]) eots.insert(eots.size(), 1'b0);
				eots[len-1] = ($urandom_range(0, 9) == 0);
			end else if (kind < 85) begin
				seq.insert(seq.size(), 8'($urandom_range(0, 255)));
				eots.insert(eots.size(), $urandom_range(0, 19) == 0);
			end else begin
				len = $urandom_range(2, 4);
				cut = $urandom_range(1, len - 1);
				seq.insert(seq.size(), rand_lead(len));
				for (int i = 1; i < cut; i++) seq.insert(seq.size(), rand_cont());
				foreach (seq[i]) eots.insert(eots.size(), 1'b0);
				if ($urandom_range(0, 1)) begin
					eots[cut-1] = 1'b1;
				end else begin
					b = 8'($urandom_range(0, 191));
					if (b >= 8'h80) b = b + 8'h40;
					seq.insert(seq.size(), b);
					eots.insert(eots.size(), $urandom_range(0, 9) == 0);
				end
			end
			foreach (seq[i]) send_byte(seq[i], eots[i]);
		end
	endtask

	// receiver; one long hold-off after the 40th result so the input backs up
	initial begin
		int unsigned hold;
		int unsigned n_res;
		hold  = 0;
		n_res = 0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				ledger.check_result(code_point, is_replacement, last_of_run);
				n_res++;
				if (n_res == 40) hold = 150;
			end
			if (hold == 0 && $urandom_range(0, 99) < 3) hold = $urandom_range(6, 25);
			if ($urandom_range(0, 99) < 2) rx_calm = ~rx_calm;
			if (hold > 0) begin
				hold--;
				pop <= 1'b0;
			end else begin
				pop <= rx_calm ? 1'b1 : ($urandom_range(0, 99) < 65);
			end
		end
	end

	initial begin
		n_cycles = 0;
		while (n_cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			n_cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		int unsigned settle;
		ledger      = new();
		n_sent      = 0;
		tx_calm     = 1'b0;
		rx_calm     = 1'b0;
		arst_n      = 1'b0;
		push        = 1'b0;
		pop         = 1'b0;
		text_byte   = 8'h00;
		end_of_text = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_byte(8'h00, 1'b0);
		send_byte(8'h41, 1'b1);
		send_byte(8'hC2, 1'b0);
		send_byte(8'hA9, 1'b0);
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b0);
		send_byte(8'hAC, 1'b0);
		send_byte(8'hF0, 1'b0);
		send_byte(8'h9F, 1'b0);
		send_byte(8'h98, 1'b0);
		send_byte(8'h80, 1'b0);
		// genuine U+FFFD, not a substitution
		send_byte(8'hEF, 1'b0);
		send_byte(8'hBF, 1'b0);
		send_byte(8'hBD, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		// bad continuation after two buffered: four results
		send_byte(8'hF0, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h41, 1'b0);
		// text ends mid-sequence
		send_byte(8'hE2, 1'b0);
		send_byte(8'h82, 1'b1);
		send_byte(8'hC3, 1'b1);
		// bad continuation that is itself a lead at end of text
		send_byte(8'hC3, 1'b0);
		send_byte(8'hE2, 1'b1);

		send_random_text();
		push <= 1'b0;

		settle = 0;
		while (ledger.due.size() != 0 && settle < 20000) begin
			@(posedge clk);
			settle++;
		end
		repeat (20) @(posedge clk);
		if (ledger.due.size() != 0) begin
			ledger.errors++;
			$display("%0t: %0d results never arrived", $time, ledger.due.size());
		end
		if (ledger.errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
